@@ rtl/core/wtr_pkg.sv @@
// Package: shared types and opcodes for width threshold reachability.
package wtr_pkg;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  node_a;
		logic [7:0]  node_b;
		logic [15:0] width;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic reachable;
	} out_item_t;

endpackage

@@ rtl/core/wtr_ram.sv @@
// Generic single port write, single port read RAM with registered read data.
module wtr_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/width_threshold_reachability.sv @@
// Top level: edge store with width-threshold reachability queries.
//
// Usage: items enter on the in channel (in_valid/in_stall, payload in_data)
// and each item gives exactly one result on the out channel
// (out_valid/out_stall, payload out_data). One item is worked on at a time.
// Clear and add pass through the OUT state to the output register. A query
// first sweeps the visited map, one node a cycle over all MAX_NODES entries,
// then walks depth first: each popped node costs one stack read plus one
// pass over the stored edges, each pass read through the single read port
// of the edge RAM.
// Reset clears the edge count and control state; visited bits are cleared by
// the sweep at the start of each query, so no pass runs after reset.
// A finished result sits in the output register; while out_stall is high it
// holds, and the next item is accepted only once that register is free or
// is being taken in the same cycle.
module width_threshold_reachability import wtr_pkg::*; #(
	parameter int MAX_NODES  = 256,
	parameter int MAX_EDGES  = 1024,
	parameter int WIDTH_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int TW = $clog2(MAX_NODES + 1);
	localparam int EDW = 2 * NW + WIDTH_BITS + 2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_POP   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [TW-1:0]         top_q;
	logic [NW-1:0]         cur_q;
	logic [NW-1:0]         sweep_q;
	logic [NW-1:0]         dst_q;
	logic [WIDTH_BITS-1:0] minw_q;
	logic                  rd_s1;
	logic                  reach_q;
	logic                  stat_q;
	logic                  oval_q;

	// Edge RAM: {a_ok, b_ok, end_a, end_b, width}
	logic           e_we;
	logic [EW-1:0]  e_waddr, e_raddr;
	logic [EDW-1:0] e_wdata, e_rdata;
	// Visited map RAM
	logic           v_we;
	logic [NW-1:0]  v_waddr, v_raddr;
	logic           v_wdata, v_rdata;
	// Pending stack RAM
	logic           s_we;
	logic [NW-1:0]  s_waddr, s_raddr;
	logic [NW-1:0]  s_wdata, s_rdata;

	wtr_ram #(.DATA_W(EDW), .DEPTH(MAX_EDGES)) u_edge (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata));
	wtr_ram #(.DATA_W(1), .DEPTH(MAX_NODES)) u_vis (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata));
	wtr_ram #(.DATA_W(NW), .DEPTH(MAX_NODES)) u_stk (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));

	logic in_fire, out_fire;
	assign out_fire = oval_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (oval_q && out_stall);
	assign in_fire  = in_valid && !in_stall;

	// Range checks on incoming nodes
	logic a_ok, b_ok;
	assign a_ok = ({24'd0, in_data.node_a} < 32'(MAX_NODES));
	assign b_ok = ({24'd0, in_data.node_b} < 32'(MAX_NODES));

	// Decode edge read data
	logic                  ed_aok, ed_bok;
	logic [NW-1:0]         ed_a, ed_b;
	logic [WIDTH_BITS-1:0] ed_w;
	assign {ed_aok, ed_bok, ed_a, ed_b, ed_w} = e_rdata;

	// Neighbour found on the edge read last cycle
	logic          hit;
	logic [NW-1:0] other;
	always_comb begin
		hit   = 1'b0;
		other = ed_b;
		if (rd_s1 && ed_w >= minw_q) begin
			if (ed_aok && ed_a == cur_q) begin
				hit   = ed_bok;
				other = ed_b;
			end else if (ed_bok && ed_b == cur_q) begin
				hit   = ed_aok;
				other = ed_a;
			end
		end
	end

	// Visited lookup of the neighbour: a write in the same pass may have hit
	// the same node in the previous cycle, so forward the last write.
	logic          vw_s1;
	logic [NW-1:0] vwa_s1;
	logic          push;
	logic [NW-1:0] nb_s2;
	logic          nb_ok_s2;
	logic          seen;
	assign seen = v_rdata || (vw_s1 && vwa_s1 == nb_s2);
	assign push = nb_ok_s2 && !seen;

	// Memory port steering
	always_comb begin
		e_we    = 1'b0;
		e_waddr = count_q[EW-1:0];
		e_wdata = {a_ok, b_ok, NW'(in_data.node_a), NW'(in_data.node_b),
			WIDTH_BITS'(in_data.width)};
		e_raddr = idx_q[EW-1:0];
		v_we    = 1'b0;
		v_waddr = sweep_q;
		v_wdata = 1'b0;
		v_raddr = hit ? other : dst_q;
		s_we    = 1'b0;
		s_waddr = top_q[NW-1:0];
		s_wdata = nb_s2;
		s_raddr = NW'(top_q - TW'(1));
		if (in_fire && in_data.opcode == OP_ADD && count_q < CW'(MAX_EDGES)) begin
			e_we = 1'b1;
		end
		case (state_q)
			ST_SWEEP: begin
				v_we = 1'b1;
				if (sweep_q == dst_q) begin
					v_wdata = 1'b0;
				end
				if (sweep_q == cur_q) begin
					v_wdata = 1'b1;
				end
				// Seed the pending stack with the source
				if (sweep_q == '0) begin
					s_we    = 1'b1;
					s_waddr = '0;
					s_wdata = cur_q;
				end
			end
			ST_SCAN: begin
				if (push) begin
					v_we    = 1'b1;
					v_waddr = nb_s2;
					v_wdata = 1'b1;
					s_we    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			oval_q   <= 1'b0;
			rd_s1    <= 1'b0;
			nb_ok_s2 <= 1'b0;
			vw_s1    <= 1'b0;
		end else begin
			if (out_fire) begin
				oval_q <= 1'b0;
			end
			vw_s1  <= v_we && state_q == ST_SCAN;
			vwa_s1 <= v_waddr;
			case (state_q)
				ST_IDLE: begin
					rd_s1    <= 1'b0;
					nb_ok_s2 <= 1'b0;
					if (in_fire) begin
						stat_q  <= 1'b0;
						reach_q <= 1'b0;
						cur_q   <= NW'(in_data.node_a);
						dst_q   <= NW'(in_data.node_b);
						minw_q  <= WIDTH_BITS'(in_data.width);
						sweep_q <= '0;
						top_q   <= TW'(1);
						case (in_data.opcode)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_OUT;
							end
							OP_ADD: begin
								if (count_q < CW'(MAX_EDGES)) begin
									count_q <= count_q + CW'(1);
								end else begin
									stat_q <= 1'b1;
								end
								state_q <= ST_OUT;
							end
							OP_QUERY: begin
								state_q <= (a_ok && b_ok) ? ST_SWEEP : ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + NW'(1);
					if (sweep_q == NW'(MAX_NODES - 1)) begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					// stack data for top-1 valid next cycle; start edge pass
					if (top_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						top_q   <= top_q - TW'(1);
						idx_q   <= '0;
						state_q <= ST_SCAN;
						rd_s1   <= 1'b0;
						nb_ok_s2 <= 1'b0;
						cur_q   <= s_rdata;
						sweep_q <= '0;
					end
				end
				ST_SCAN: begin
					// first cycle takes cur from stack read data
					if (sweep_q == '0 && !rd_s1 && idx_q == '0) begin
						cur_q <= s_rdata;
					end
					sweep_q  <= NW'(1);
					rd_s1    <= idx_q < count_q;
					if (idx_q < count_q) begin
						idx_q <= idx_q + CW'(1);
					end
					nb_ok_s2 <= hit;
					nb_s2    <= other;
					if (push && top_q < TW'(MAX_NODES)) begin
						top_q <= top_q + TW'(1);
					end
					if (idx_q >= count_q && !rd_s1 && !hit) begin
						state_q <= ST_POP;
					end
				end
				ST_DONE: begin
					// v_raddr shows dst while no hit
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!oval_q || out_fire) begin
						if (rd_s1) begin
							reach_q <= v_rdata;
						end
						oval_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE) begin
				rd_s1 <= 1'b1;
			end
		end
	end

	assign out_valid          = oval_q;
	assign out_data.status    = stat_q;
	assign out_data.reachable = reach_q;

endmodule

@@ rtl/core/wtr_checker.sv @@
// Checker: port-level properties of width threshold reachability, and its bind.
module wtr_checker import wtr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Status and reachable never both set (only an add reports a full store, only a query reachable)
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.status && out_data.reachable))
		else $error("status and reachable both set");

	// An accepted item blocks further transfers the next cycle
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken back to back");

	// A clear never reports an error
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.opcode == OP_CLEAR && !out_valid
		|=> ##1 out_valid && !out_data.status)
		else $error("clear reported error");

endmodule

bind width_threshold_reachability wtr_checker u_wtr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data));

@@ sim/width_threshold_reachability_test.sv @@
// Testbench for the width threshold reachability block: graph model, random traffic, checks.
module width_threshold_reachability_test import wtr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODE_LIMIT = 256;
	localparam int EDGE_LIMIT = 1024;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	width_threshold_reachability u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// Graph state mirrored from the block
	logic [7:0]  edge_end_a [EDGE_LIMIT];
	logic [7:0]  edge_end_b [EDGE_LIMIT];
	logic [15:0] edge_w [EDGE_LIMIT];
	int          edge_total = 0;

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int        sender_idle_pct = 17;
	int        receiver_idle_pct = 53;
	bit        sender_hold = 1'b0;
	int        mismatches = 0;
	int        results_seen = 0;
	int        queries_reached = 0;
	int        stores_full = 0;
	bit        stimulus_done = 1'b0;

	// Depth first walk over edges no narrower than the threshold
	function automatic logic graph_reaches(logic [7:0] src, logic [7:0] dst,
			logic [15:0] min_w);
		bit seen [NODE_LIMIT];
		logic [7:0] stack [$];
		logic [7:0] cur;
		logic [7:0] other;
		seen[src] = 1'b1;
		stack.push_back(src);
		while (stack.size() > 0) begin
			cur = stack.pop_back();
			for (int i = 0; i < edge_total; i++) begin
				if (edge_w[i] < min_w) continue;
				if (edge_end_a[i] == cur) other = edge_end_b[i];
				else if (edge_end_b[i] == cur) other = edge_end_a[i];
				else continue;
				if (seen[other]) continue;
				seen[other] = 1'b1;
				stack.push_back(other);
			end
		end
		return seen[dst];
	endfunction

	// Advance the mirror by one item and return its result
	function automatic out_item_t graph_step(in_item_t item);
		out_item_t res;
		res = '0;
		case (item.opcode)
			OP_CLEAR: edge_total = 0;
			OP_ADD: begin
				if (edge_total < EDGE_LIMIT) begin
					edge_end_a[edge_total] = item.node_a;
					edge_end_b[edge_total] = item.node_b;
					edge_w[edge_total] = item.width;
					edge_total++;
				end else begin
					res.status = 1'b1;
				end
			end
			OP_QUERY: res.reachable = graph_reaches(item.node_a, item.node_b, item.width);
			default: ;
		endcase
		return res;
	endfunction

	function automatic in_item_t make_item(logic [1:0] op, logic [7:0] a, logic [7:0] b,
			logic [15:0] w);
		in_item_t item;
		item.opcode = op;
		item.node_a = a;
		item.node_b = b;
		item.width = w;
		return item;
	endfunction

	// Drive transfers: predict on acceptance, then present the next item
	always @(posedge clk) begin
		in_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(graph_step(in_data));
				if (expected_results[$].status) stores_full++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && !sender_hold &&
						$urandom_range(99) >= sender_idle_pct) begin
					nxt = pending_items.pop_front();
					in_data <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Stall the receiver at random
	always @(posedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status=%0b reachable=%0b",
						out_data.status, out_data.reachable);
			end else begin
				want = expected_results.pop_front();
				if (want.reachable) queries_reached++;
				if (out_data.status !== want.status || out_data.reachable !== want.reachable) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status exp %0b got %0b, reachable exp %0b got %0b",
							want.status, out_data.status, want.reachable, out_data.reachable);
				end
			end
		end
	end

	task automatic drain;
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	// Clear, add 3 to 12 random edges with random widths, then make 8 random queries
	task automatic load_graph_burst(int node_span);
		int n_edges;
		n_edges = $urandom_range(12, 3);
		pending_items.push_back(make_item(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom)));
		for (int i = 0; i < n_edges; i++)
			pending_items.push_back(make_item(OP_ADD, 8'($urandom_range(node_span)),
				8'($urandom_range(node_span)), 16'($urandom_range(40))));
		for (int i = 0; i < 8; i++)
			pending_items.push_back(make_item(OP_QUERY, 8'($urandom_range(node_span)),
				8'($urandom_range(node_span)), 16'($urandom_range(45))));
	endtask

	initial begin
		int sent;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, all opcodes, self loops, parallel edges, source equals destination
		pending_items.push_back(make_item(OP_QUERY, 8'd0, 8'd0, 16'd0));
		pending_items.push_back(make_item(OP_QUERY, 8'd255, 8'd255, 16'hFFFF));
		pending_items.push_back(make_item(OP_QUERY, 8'd0, 8'd255, 16'd0));
		pending_items.push_back(make_item(OP_ADD, 8'd0, 8'd255, 16'hFFFF));
		pending_items.push_back(make_item(OP_ADD, 8'd255, 8'd7, 16'd0));
		pending_items.push_back(make_item(OP_ADD, 8'd7, 8'd7, 16'd5));
		pending_items.push_back(make_item(OP_ADD, 8'd0, 8'd255, 16'd1));
		pending_items.push_back(make_item(OP_QUERY, 8'd0, 8'd255, 16'hFFFF));
		pending_items.push_back(make_item(OP_QUERY, 8'd0, 8'd7, 16'd0));
		pending_items.push_back(make_item(OP_QUERY, 8'd7, 8'd0, 16'd1));
		pending_items.push_back(make_item(OP_QUERY, 8'd255, 8'd0, 16'hFFFF));
		pending_items.push_back(make_item(OP_SPARE, 8'hAA, 8'h55, 16'hA5A5));
		pending_items.push_back(make_item(OP_SPARE, 8'h55, 8'hAA, 16'h5A5A));
		pending_items.push_back(make_item(OP_CLEAR, 8'hFF, 8'hFF, 16'hFFFF));
		pending_items.push_back(make_item(OP_QUERY, 8'd0, 8'd255, 16'd0));
		drain();

		// Every result is back; hold the sender idle before the random phases
		sender_hold = 1'b1;
		repeat (20) @(posedge clk);
		sender_hold = 1'b0;

		// Random graph sessions across three idling phases
		sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 53 : 0;
			receiver_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 17 : 0;
			while (sent < (phase + 1) * 92) begin
				if ($urandom_range(9) == 0) begin
					pending_items.push_back(make_item(2'($urandom), 8'($urandom),
						8'($urandom), 16'($urandom)));
					sent++;
				end else begin
					load_graph_burst(($urandom_range(3) == 0) ? 255 : 12);
					sent += pending_items.size();
				end
				drain();
			end
		end
		stimulus_done = 1'b1;
		repeat (50) @(posedge clk);
		$display("Covered %0d results, %0d reachable queries, %0d store-full drops.",
			results_seen, queries_reached, stores_full);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Bound the run
	initial begin
		#50ms;
		$display("Timeout reached");
		$display("Some tests failed");
		$finish;
	end

endmodule
